// ===== rtl/hpq_pkg.sv =====
`timescale 1ns / 1ps

package hpq_pkg;

    // Table depth; node ids index the tables modulo this depth (power of two)
    localparam int NODE_COUNT  = 1024;
    localparam int ADDR_W      = $clog2(NODE_COUNT);
    localparam int ID_W        = 10;
    localparam int MAX_RESULTS = 21;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 48;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;
    localparam logic KIND_NODE  = 1'b0;
    localparam logic KIND_EDGE  = 1'b1;

    typedef logic [ID_W-1:0]   id_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // One node's table entry
    typedef struct packed {
        id_t  pre;
        id_t  head;
        logic par_valid;
        id_t  par;
    } entry_t;

    // Unpacked input request
    typedef struct packed {
        logic command;
        id_t  node_a;
        id_t  node_b;
        id_t  preorder_index;
        id_t  chain_head;
        id_t  parent_node;
        logic has_parent;
        logic range_kind;
    } req_t;

    // One result item
    typedef struct packed {
        logic          range_valid;
        id_t           range_low;
        logic [ID_W:0] range_high;
        logic          last;
        id_t           common_ancestor;
        id_t           path_edges;
    } result_t;

    function automatic addr_t slot(input id_t id);
        slot = addr_t'(id);
    endfunction

    function automatic id_t node_id(input addr_t a);
        node_id = id_t'(a);
    endfunction

endpackage

// ===== rtl/heavy_path_interval_query_top.sv =====
`timescale 1ns / 1ps

// Heavy-light path interval query.
// Slave side (s_*) takes requests. A load request (tuser command = 0) writes
// one node's preorder index, heavy-path head and parent into the tables and
// yields no result. A query request (command = 1) names two nodes and walks
// heavy paths from the deeper-in-preorder endpoint, giving one half-open
// preorder interval per path segment on the master side (m_*); tlast marks
// the final one, which also carries the lowest common ancestor and the edge
// count of the path.
// The walk takes a compare step and a head read per climbed segment, plus
// a closing compare, with the registered table reads in series. A query
// gives up to 21 results; s_tready stays low during the walk.
// Reset clears the control path only: the tables hold nothing defined until
// loaded, so every node a query touches must have been loaded first.
// When the receiver stalls, the walk holds at its current segment; the
// output register lets the next request in while the final result waits.
module heavy_path_interval_query_top
    import hpq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // node_a, node_b, preorder_index, chain_head, parent_node, has_parent, pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // command, range_kind
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // range_low, range_high, common_ancestor, path_edges, pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    // range_valid
    output logic [0:0]             m_tuser
);

    req_t    req;
    result_t res;
    logic    res_valid;
    logic    res_ready;

    // Unpack the request fields from the stream word
    always_comb
    begin
        req.command        = s_tuser[0];
        req.range_kind     = s_tuser[1];
        req.node_a         = s_tdata[9:0];
        req.node_b         = s_tdata[19:10];
        req.preorder_index = s_tdata[29:20];
        req.chain_head     = s_tdata[39:30];
        req.parent_node    = s_tdata[49:40];
        req.has_parent     = s_tdata[50];
    end

    hpq_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    hpq_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/hpq_ram.sv =====
`timescale 1ns / 1ps

module hpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data when no read is issued
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/hpq_walker.sv =====
`timescale 1ns / 1ps

module hpq_walker
    import hpq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  req_t    req,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_HEAD
    } state_t;

    state_t            state_reg;
    logic              first_reg;
    logic              climb_reg;
    logic              edge_reg;
    logic [CNT_W-1:0]  count_reg;
    addr_t             u_reg;
    addr_t             v_reg;
    entry_t            eu_reg;
    entry_t            ev_reg;
    id_t               edges_reg;

    logic              tbl_we;
    addr_t             tbl_waddr;
    entry_t            tbl_wdata;
    logic              re_a;
    logic              re_b;
    addr_t             raddr_a;
    addr_t             raddr_b;
    entry_t            rd_a;
    entry_t            rd_b;

    entry_t            eu_cur;
    entry_t            ev_cur;
    logic              swap;
    addr_t             u_sw;
    addr_t             v_sw;
    entry_t            eu_sw;
    entry_t            ev_sw;
    addr_t             h;
    logic              same;
    result_t           fin_res;
    result_t           head_res;
    id_t               edges_next;
    logic              stop;
    logic              accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    // Both copies of the table take every load
    assign tbl_we    = accept && (req.command == CMD_LOAD);
    assign tbl_waddr = slot(req.node_a);
    assign tbl_wdata = '{pre: req.preorder_index, head: req.chain_head,
                         par_valid: req.has_parent, par: req.parent_node};

    hpq_ram #(.WIDTH($bits(entry_t)), .DEPTH(NODE_COUNT)) u_ram_a (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (re_a),
        .raddr (raddr_a),
        .rdata (rd_a)
    );

    hpq_ram #(.WIDTH($bits(entry_t)), .DEPTH(NODE_COUNT)) u_ram_b (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (re_b),
        .raddr (raddr_b),
        .rdata (rd_b)
    );

    // Compare step: order the endpoints, look at their heads
    always_comb
    begin
        eu_cur = first_reg ? rd_a : eu_reg;
        ev_cur = climb_reg ? rd_b : ev_reg;
        swap   = eu_cur.pre > ev_cur.pre;
        u_sw   = swap ? v_reg : u_reg;
        v_sw   = swap ? u_reg : v_reg;
        eu_sw  = swap ? ev_cur : eu_cur;
        ev_sw  = swap ? eu_cur : ev_cur;
        h      = slot(ev_sw.head);
        same   = (slot(eu_sw.head) == h);

        fin_res.last            = 1'b1;
        fin_res.common_ancestor = node_id(u_sw);
        fin_res.path_edges      = edges_reg + ev_sw.pre - eu_sw.pre;
        if (edge_reg == KIND_EDGE && u_sw == v_sw)
        begin
            fin_res.range_valid = 1'b0;
            fin_res.range_low   = '0;
            fin_res.range_high  = '0;
        end
        else
        begin
            fin_res.range_valid = 1'b1;
            fin_res.range_low   = (edge_reg == KIND_EDGE) ? eu_sw.pre + id_t'(1) : eu_sw.pre;
            fin_res.range_high  = {1'b0, ev_sw.pre} + (ID_W+1)'(1);
        end
    end

    // Climb step: the head entry is in RAM A
    always_comb
    begin
        edges_next = edges_reg + ev_reg.pre + id_t'(1) - rd_a.pre;
        stop = !rd_a.par_valid
            || (count_reg == CNT_W'(MAX_RESULTS - 1))
            || (edge_reg == KIND_EDGE && u_reg == slot(rd_a.par));

        head_res.range_valid     = 1'b1;
        head_res.range_low       = (edge_reg == KIND_NODE && eu_reg.pre > rd_a.pre)
                                   ? eu_reg.pre : rd_a.pre;
        head_res.range_high      = {1'b0, ev_reg.pre} + (ID_W+1)'(1);
        head_res.last            = stop;
        head_res.common_ancestor = stop ? node_id(u_reg) : '0;
        head_res.path_edges      = stop ? edges_next : '0;
    end

    always_comb
    begin
        res_valid = 1'b0;
        res       = head_res;
        re_a      = 1'b0;
        re_b      = 1'b0;
        raddr_a   = slot(req.node_a);
        raddr_b   = slot(req.node_b);
        case (state_reg)
            ST_IDLE:
            begin
                re_a = accept && (req.command == CMD_QUERY);
                re_b = re_a;
            end
            ST_CMP:
            begin
                res_valid = same;
                res       = fin_res;
                re_a      = !same;
                raddr_a   = h;
            end
            ST_HEAD:
            begin
                res_valid = 1'b1;
                re_b      = res_ready && !stop;
                raddr_b   = slot(rd_a.par);
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b0;
            climb_reg <= 1'b0;
            edge_reg  <= KIND_NODE;
            count_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && req.command == CMD_QUERY)
                    begin
                        first_reg <= 1'b1;
                        climb_reg <= 1'b1;
                        edge_reg  <= req.range_kind;
                        count_reg <= '0;
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    if (!same)
                    begin
                        first_reg <= 1'b0;
                        climb_reg <= 1'b0;
                        state_reg <= ST_HEAD;
                    end
                    else if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_HEAD:
                begin
                    if (res_ready)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        if (stop)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            climb_reg <= 1'b1;
                            state_reg <= ST_CMP;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Endpoint ids, cached entries and the running edge count
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            u_reg     <= slot(req.node_a);
            v_reg     <= slot(req.node_b);
            edges_reg <= '0;
        end
        else if (state_reg == ST_CMP && !same)
        begin
            u_reg  <= u_sw;
            v_reg  <= v_sw;
            eu_reg <= eu_sw;
            ev_reg <= ev_sw;
        end
        else if (state_reg == ST_HEAD && res_ready)
        begin
            v_reg     <= slot(rd_a.par);
            edges_reg <= edges_next;
        end
    end

endmodule

// ===== rtl/hpq_out.sv =====
`timescale 1ns / 1ps

module hpq_out
    import hpq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   res_valid,
    output logic                   res_ready,
    input  result_t                res,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    output logic [0:0]             m_tuser
);

    logic    valid_reg;
    result_t res_reg;

    // Take a new result whenever the slot is empty or being drained
    assign res_ready = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_TDATA_W'({res_reg.path_edges, res_reg.common_ancestor,
                                    res_reg.range_high, res_reg.range_low});
    assign m_tlast  = res_reg.last;
    assign m_tuser  = res_reg.range_valid;

endmodule

// ===== dv/tb_heavy_path_interval_query_top.sv =====
`timescale 1ns / 1ps

// Request packing on the slave side:
//   s_tdata : node_a [9:0], node_b [19:10], preorder_index [29:20],
//             chain_head [39:30], parent_node [49:40], has_parent [50], zero pad
//   s_tuser : command [0], range_kind [1]
// Result packing on the master side:
//   m_tdata : range_low [9:0], range_high [20:10], common_ancestor [30:21],
//             path_edges [40:31], zero pad
//   m_tlast : last, m_tuser : range_valid
module tb_heavy_path_interval_query_top;
    import hpq_pkg::*;

    // No-handshake stretch that counts as a hang; the longest legal one is the
    // receiver hold-off below plus random stalls.
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_OFF     = 400;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic [0:0]             m_tuser;

    // Stimulus side
    req_t    pending_requests[$];
    req_t    offered;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      rx_hold       = 0;

    // Prediction side: a private copy of the node tables and the results owed
    id_t           preorder_tbl[NODE_COUNT];
    id_t           head_tbl[NODE_COUNT];
    logic [ID_W:0] parent_tbl[NODE_COUNT];
    result_t       expected_segments[$];

    int      errors       = 0;
    int      quiet_cycles = 0;

    // Generator bookkeeping: which ids hold an entry, and the current tree
    bit      loaded[NODE_COUNT];
    id_t     loaded_ids[$];
    id_t     tree_nodes[$];

    always #5 clk = ~clk;

    heavy_path_interval_query_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Walk the heavy paths for one query and queue the segments it must give.
    // Each round takes the endpoint later in preorder and climbs to the head of
    // its chain; the round where both endpoints share a chain closes the walk.
    function automatic void climb_paths(input id_t a, input id_t b, input logic kind);
        id_t     u;
        id_t     v;
        id_t     t;
        id_t     h;
        int      ou;
        int      ov;
        int      oh;
        int      edges;
        result_t seg;
        result_t segs[$];
        u = a;
        v = b;
        edges = 0;
        while (segs.size() < MAX_RESULTS)
        begin
            if (preorder_tbl[u] > preorder_tbl[v])
            begin
                t = u;
                u = v;
                v = t;
            end
            ou = preorder_tbl[u];
            ov = preorder_tbl[v];
            h  = head_tbl[v];
            oh = preorder_tbl[h];
            seg = '0;
            seg.range_valid = 1'b1;
            seg.range_high  = 11'(ov + 1);
            if (head_tbl[u] == h)
            begin
                // Same chain: the closing interval; an edge walk drops the
                // ancestor itself, and with equal ends there is nothing left.
                if (kind == KIND_NODE)
                begin
                    seg.range_low = id_t'(ou);
                    segs = {segs, seg};
                end
                else if (u != v)
                begin
                    seg.range_low = id_t'(ou + 1);
                    segs = {segs, seg};
                end
                edges += ov - ou;
                break;
            end
            seg.range_low = id_t'((kind == KIND_NODE && ou > oh) ? ou : oh);
            segs = {segs, seg};
            edges += ov + 1 - oh;
            // A chain head without a parent ends the walk early
            if (!parent_tbl[h][ID_W])
                break;
            v = parent_tbl[h][ID_W-1:0];
        end
        if (segs.size() == 0)
        begin
            seg = '0;
            segs = {segs, seg};
        end
        seg = segs.pop_back();
        seg.last            = 1'b1;
        seg.common_ancestor = u;
        seg.path_edges      = id_t'(edges);
        segs = {segs, seg};
        foreach (segs[i])
            expected_segments = {expected_segments, segs[i]};
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // Driver: predict on acceptance, then offer the next pending request
    // unless this cycle idles. tvalid never drops while a request waits.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (offered.command == CMD_LOAD)
                begin
                    preorder_tbl[offered.node_a] = offered.preorder_index;
                    head_tbl[offered.node_a]     = offered.chain_head;
                    parent_tbl[offered.node_a]   = {offered.has_parent, offered.parent_node};
                end
                else
                    climb_paths(offered.node_a, offered.node_b, offered.range_kind);
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_TDATA_W'({offered.has_parent, offered.parent_node,
                                             offered.chain_head, offered.preorder_index,
                                             offered.node_b, offered.node_a});
                    s_tuser  <= {offered.range_kind, offered.command};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result against the oldest one owed, and
    // drive tready, honouring a long hold-off when one is requested.
    always @(posedge clk or negedge rst_n)
    begin : rx
        result_t seen;
        result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.range_valid     = m_tuser[0];
                seen.range_low       = m_tdata[9:0];
                seen.range_high      = m_tdata[20:10];
                seen.last            = m_tlast;
                seen.common_ancestor = m_tdata[30:21];
                seen.path_edges      = m_tdata[40:31];
                if (expected_segments.size() == 0)
                begin
                    $error("result with no query outstanding: low %0d high %0d last %0b",
                           seen.range_low, seen.range_high, seen.last);
                    errors++;
                end
                else
                begin
                    want = expected_segments.pop_front();
                    compare_field("range_valid", want.range_valid, seen.range_valid);
                    compare_field("range_low", want.range_low, seen.range_low);
                    compare_field("range_high", want.range_high, seen.range_high);
                    compare_field("last", want.last, seen.last);
                    compare_field("common_ancestor", want.common_ancestor,
                                  seen.common_ancestor);
                    compare_field("path_edges", want.path_edges, seen.path_edges);
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: abort if neither side moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Queue a table write; fields the block ignores on a load get noise
    task automatic load_node(input id_t node, input int pre, input id_t head,
                             input id_t par, input logic has_par);
        req_t r;
        r.command        = CMD_LOAD;
        r.node_a         = node;
        r.node_b         = id_t'($urandom);
        r.preorder_index = id_t'(pre);
        r.chain_head     = head;
        r.parent_node    = par;
        r.has_parent     = has_par;
        r.range_kind     = 1'($urandom);
        pending_requests = {pending_requests, r};
        if (!loaded[node])
        begin
            loaded[node] = 1'b1;
            loaded_ids = {loaded_ids, node};
        end
    endtask

    task automatic query_nodes(input id_t a, input id_t b, input logic kind);
        req_t r;
        r.command        = CMD_QUERY;
        r.node_a         = a;
        r.node_b         = b;
        r.preorder_index = id_t'($urandom);
        r.chain_head     = id_t'($urandom);
        r.parent_node    = id_t'($urandom);
        r.has_parent     = 1'($urandom);
        r.range_kind     = kind;
        pending_requests = {pending_requests, r};
    endtask

    // Build a random rooted tree on distinct random ids, decompose it into
    // heavy paths (heavy child visited first in preorder) and queue its loads.
    // A small window gives deep, narrow trees with many light edges.
    task automatic grow_tree(input int n, input int window);
        int  par_idx[NODE_COUNT];
        int  sz[NODE_COUNT];
        int  heavy[NODE_COUNT];
        int  pre_idx[NODE_COUNT];
        int  head_idx[NODE_COUNT];
        id_t ids[NODE_COUNT];
        bit  taken[NODE_COUNT];
        int  dfs[$];
        int  x;
        int  nxt;
        int  base;
        for (int i = 0; i < n; i++)
        begin
            do
                x = $urandom_range(NODE_COUNT - 1);
            while (taken[x]);
            taken[x] = 1'b1;
            ids[i]   = id_t'(x);
            sz[i]    = 1;
            heavy[i] = -1;
        end
        par_idx[0] = -1;
        for (int i = 1; i < n; i++)
            par_idx[i] = $urandom_range(i - 1, (i > window) ? i - window : 0);
        for (int i = n - 1; i > 0; i--)
            sz[par_idx[i]] += sz[i];
        for (int i = 1; i < n; i++)
            if (heavy[par_idx[i]] < 0 || sz[i] > sz[heavy[par_idx[i]]])
                heavy[par_idx[i]] = i;
        head_idx[0] = 0;
        for (int i = 1; i < n; i++)
            head_idx[i] = (heavy[par_idx[i]] == i) ? head_idx[par_idx[i]] : i;
        // Push light children first so the heavy child comes straight after
        nxt = 0;
        dfs = {dfs, 0};
        while (dfs.size() > 0)
        begin
            x = dfs.pop_back();
            pre_idx[x] = nxt++;
            for (int c = 1; c < n; c++)
                if (par_idx[c] == x && c != heavy[x])
                    dfs = {dfs, c};
            if (heavy[x] >= 0)
                dfs = {dfs, heavy[x]};
        end
        // Shift the whole preorder so the top of the range gets exercised
        base = $urandom_range(NODE_COUNT - n);
        tree_nodes.delete();
        for (int i = 0; i < n; i++)
        begin
            load_node(ids[i], base + pre_idx[i], ids[head_idx[i]],
                      (i == 0) ? id_t'($urandom) : ids[par_idx[i]], i != 0);
            tree_nodes = {tree_nodes, ids[i]};
        end
    endtask

    // Hold until the bus is empty and every owed result has arrived
    task automatic wait_drained();
        wait (pending_requests.size() == 0 && !s_tvalid && expected_segments.size() == 0);
        @(negedge clk);
    endtask

    // One random phase: a fresh tree, then mostly well-formed queries on it,
    // with some cross-tree queries and stray table writes as noise. Stray
    // writes only point at ids already loaded, so no walk reads an empty entry.
    task automatic run_phase(input int n, input int queries);
        int  roll;
        id_t a;
        grow_tree(n, $urandom_range(4, 1));
        repeat (queries)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
                load_node(id_t'($urandom_range(NODE_COUNT - 1)), $urandom_range(NODE_COUNT - 1),
                          loaded_ids[$urandom_range(loaded_ids.size() - 1)],
                          loaded_ids[$urandom_range(loaded_ids.size() - 1)], 1'($urandom));
            else if (roll < 16)
                query_nodes(loaded_ids[$urandom_range(loaded_ids.size() - 1)],
                            loaded_ids[$urandom_range(loaded_ids.size() - 1)], 1'($urandom));
            else if (roll < 24)
            begin
                a = tree_nodes[$urandom_range(tree_nodes.size() - 1)];
                query_nodes(a, a, 1'($urandom));
            end
            else
                query_nodes(tree_nodes[$urandom_range(tree_nodes.size() - 1)],
                            tree_nodes[$urandom_range(tree_nodes.size() - 1)], 1'($urandom));
        end
        wait_drained();
    endtask

    initial
    begin
        int sizes[9];
        sizes = '{10, 14, 5, 64, 12, 16, 8, 20, 12};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 13;
        recv_idle_pct = 51;

        // Hand-built tree at the top of the preorder range:
        // root 0 with heavy chain 0-1023-512, light child 341 under 1023,
        // light child 682 under the root.
        load_node(10'd0, 1019, 10'd0, 10'd1023, 1'b0);
        load_node(10'd1023, 1020, 10'd0, 10'd0, 1'b1);
        load_node(10'd512, 1021, 10'd0, 10'd1023, 1'b1);
        load_node(10'd341, 1022, 10'd341, 10'd1023, 1'b1);
        load_node(10'd682, 1023, 10'd682, 10'd0, 1'b1);
        // A lone root, and two heads that name each other as parent
        load_node(10'd100, 5, 10'd100, 10'd0, 1'b0);
        load_node(10'd200, 10, 10'd200, 10'd201, 1'b1);
        load_node(10'd201, 11, 10'd201, 10'd200, 1'b1);
        query_nodes(10'd341, 10'd682, KIND_NODE);
        query_nodes(10'd341, 10'd682, KIND_EDGE);
        query_nodes(10'd512, 10'd512, KIND_EDGE);   // equal ends, edge walk
        query_nodes(10'd682, 10'd682, KIND_NODE);   // interval ending at 1024
        query_nodes(10'd0, 10'd1023, KIND_EDGE);
        query_nodes(10'd682, 10'd0, KIND_NODE);
        query_nodes(10'd1023, 10'd341, KIND_EDGE);  // closing segment comes out empty
        query_nodes(10'd100, 10'd341, KIND_NODE);   // separate trees: chain breaks
        query_nodes(10'd100, 10'd201, KIND_NODE);   // endless climb, cut at the cap
        query_nodes(10'd201, 10'd100, KIND_EDGE);
        // Two nodes on one chain both at the last preorder slot: low wraps
        load_node(10'd300, 1023, 10'd682, 10'd682, 1'b1);
        query_nodes(10'd682, 10'd300, KIND_EDGE);
        query_nodes(10'd300, 10'd300, KIND_NODE);
        wait_drained();

        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 3)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 13;
            end
            else if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Starve the output for a long stretch so the block backs up
            if (ph == 1 || ph == 6)
                rx_hold = HOLD_OFF;
            run_phase(sizes[ph], 18);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_segments.size() != 0)
        begin
            $error("%0d results never arrived", expected_segments.size());
            errors++;
        end
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
